FILE: rtl/iir_transposed_direct_form2_assert.svh
// assertion macros for the transposed direct-form-ii iir filter
// each macro expects i_clk and i_rst_n in the scope where it is used
`ifndef IIR_TRANSPOSED_DIRECT_FORM2_ASSERT_SVH
`define IIR_TRANSPOSED_DIRECT_FORM2_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ITD2_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ITD2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/itd2_pkg.sv
`timescale 1ns / 1ps

package itd2_pkg;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_NUMER  = 2'd1;
    localparam logic [1:0] OP_DENOM  = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK  = 2'd1;

    // fixed widths of the datapath
    localparam int COEF_W   = 48;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 64;
    localparam int TAPS_W   = 5;

    // input transaction
    typedef struct packed {
        logic [1:0]                 op;
        logic [3:0]                 coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } t_out_item;

endpackage

FILE: rtl/iir_transposed_direct_form2.sv
`timescale 1ns / 1ps

// Transposed direct-form-II IIR filter with one shared 48x16 multiplier. A coefficient
// write (op 1 or 2) leaves the input ready for the next transaction. A sample stalls the
// input from acceptance until it is done, over the n taps in use: accept, three steps for
// tap zero and the output, three for each further tap (b*x, a*y, delay write), and one to
// clear the unused delay elements, as the single multiplier visits b[i]*x and a[i]*y
// in turn for every tap. A result waiting on a stalled output holds the sequencer at
// the output step; otherwise a new transaction is taken while the previous result
// still waits.
module iir_transposed_direct_form2
    import itd2_pkg::*;
#(
    parameter int MAX_TAPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_TAPS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MULB = 7'b0000010,
        S_SUM0 = 7'b0000100,
        S_OUT  = 7'b0001000,
        S_MULA = 7'b0010000,
        S_WR   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_idx, n_idx;
    logic [IW-1:0]              r_last, n_last;
    logic                       r_fb;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;

    logic [TAPS_W-1:0]          r_tap_count;
    logic                       r_fb_en;

    // coefficient and delay memories with per-entry valid bits
    logic signed [COEF_W-1:0]   r_b_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   r_a_mem [MAX_TAPS];
    logic [ACC_W-1:0]           r_d_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]        r_b_vld;
    logic [MAX_TAPS-1:0]        r_a_vld;
    logic [MAX_TAPS-1:0]        r_d_vld;
    logic signed [COEF_W-1:0]   r_b_q;
    logic signed [COEF_W-1:0]   r_a_q;
    logic [ACC_W-1:0]           r_d_q;

    logic [ACC_W-1:0]           r_prod;
    logic [ACC_W-1:0]           r_next;
    logic [ACC_W-1:0]           r_acc;

    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       w_accept;
    logic                       w_coef_ok;
    logic [IW-1:0]              w_coef_addr;
    logic [IW-1:0]              w_wr_addr;
    logic                       w_out_free;
    logic signed [COEF_W-1:0]   w_mul_c;
    logic signed [SAMPLE_W-1:0] w_mul_s;
    logic signed [ACC_W-1:0]    w_mul;
    logic signed [24:0]         w_q;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                       w_sat;
    logic [MAX_TAPS-1:0]        w_keep;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // coefficient write address
    assign w_coef_ok   = (int'(i_in.coef_index) < MAX_TAPS);
    assign w_coef_addr = IW'(i_in.coef_index);
    assign w_wr_addr   = r_idx - IW'(1);

    // shared multiplier: b[i]*x or a[i]*y
    assign w_mul_c = (r_state == S_MULB) ? r_b_q : r_a_q;
    assign w_mul_s = (r_state == S_MULB) ? r_x : r_y;
    assign w_mul   = w_mul_c * w_mul_s;

    // round half up from q9.55 to q1.15, then saturate
    always_comb begin
        w_q   = $signed({r_acc[ACC_W-1], r_acc[ACC_W-1:40]}) + $signed({24'd0, r_acc[39]});
        w_sat = 1'b0;
        w_y   = w_q[SAMPLE_W-1:0];
        if (w_q > 25'sd32767) begin
            w_y   = 16'sh7FFF;
            w_sat = 1'b1;
        end else if (w_q < -25'sd32768) begin
            w_y   = -16'sh8000;
            w_sat = 1'b1;
        end
    end

    // delay elements kept after a sample: those below the last tap
    always_comb begin
        for (int i = 0; i < MAX_TAPS; i++) begin
            w_keep[i] = (IW'(i) < r_last);
        end
    end

    // tap count clamped to one through MAX_TAPS
    always_comb begin
        if (r_tap_count == '0) begin
            n_last = '0;
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            n_last = IW'(MAX_TAPS - 1);
        end else begin
            n_last = IW'(r_tap_count - TAPS_W'(1));
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in.op == OP_SAMPLE) begin
                    n_state = S_MULB;
                    n_idx   = '0;
                end
            end
            S_MULB: begin
                n_state = (r_idx == '0) ? S_SUM0 : S_MULA;
            end
            S_SUM0: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    if (r_last != '0) begin
                        n_state = S_MULB;
                        n_idx   = IW'(1);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MULA: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (r_idx < r_last) begin
                    n_state = S_MULB;
                    n_idx   = r_idx + IW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_tap_count <= TAPS_W'(1);
            r_fb_en     <= 1'b1;
            r_out_valid <= 1'b0;
            r_b_vld     <= '0;
            r_a_vld     <= '0;
            r_d_vld     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TAP_COUNT: r_tap_count <= i_cfg_data[TAPS_W-1:0];
                    CFG_FEEDBACK:  r_fb_en     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            // coefficient valid bits
            if (w_accept && w_coef_ok && i_in.op == OP_NUMER) begin
                r_b_vld[w_coef_addr] <= 1'b1;
            end
            if (w_accept && w_coef_ok && i_in.op == OP_DENOM) begin
                r_a_vld[w_coef_addr] <= 1'b1;
            end
            // delay valid bits: set on write, unused ones cleared at the end
            if (r_state == S_WR) begin
                r_d_vld[w_wr_addr] <= 1'b1;
            end else if (r_state == S_DONE) begin
                r_d_vld <= r_d_vld & w_keep;
            end
            // output register
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_accept && w_coef_ok && i_in.op == OP_NUMER) begin
            r_b_mem[w_coef_addr] <= i_in.coef_value;
        end
        if (w_accept && w_coef_ok && i_in.op == OP_DENOM) begin
            r_a_mem[w_coef_addr] <= i_in.coef_value;
        end
        if (r_state == S_WR) begin
            r_d_mem[w_wr_addr] <= r_acc - r_prod;
        end
        r_b_q <= r_b_vld[n_idx] ? r_b_mem[n_idx] : '0;
        r_a_q <= r_a_vld[n_idx] ? r_a_mem[n_idx] : '0;
        r_d_q <= r_d_vld[n_idx] ? r_d_mem[n_idx] : '0;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.op == OP_SAMPLE) begin
            r_x    <= i_in.sample_in;
            r_last <= n_last;
            r_fb   <= r_fb_en;
        end
        case (r_state)
            S_MULB: begin
                r_prod <= w_mul;
                r_next <= (r_idx < r_last) ? r_d_q : '0;
            end
            S_SUM0: begin
                r_acc <= r_next + r_prod;
            end
            S_OUT: begin
                r_y <= w_y;
                if (w_out_free) begin
                    r_out.sample_out <= w_y;
                    r_out.saturated  <= w_sat;
                end
            end
            S_MULA: begin
                r_acc  <= r_next + r_prod;
                r_prod <= r_fb ? w_mul : '0;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/itd2_checker.sv
`timescale 1ns / 1ps

`include "iir_transposed_direct_form2_assert.svh"

module itd2_checker
    import itd2_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    // a stalled result stays put
    `ITD2_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "output transaction changed while stalled")

    // a sample keeps the block busy afterwards
    `ITD2_ASSERT_NEXT(a_sample_busy, i_in_valid && !o_in_stall && i_in.op == OP_SAMPLE, o_in_stall, "block ready right after a sample")

    // a non-sample transaction does not make the block busy
    `ITD2_ASSERT_NEXT(a_write_quick, i_in_valid && !o_in_stall && i_in.op != OP_SAMPLE, !o_in_stall, "block busy after a coefficient write")

    // a new result only appears out of sample processing
    `ITD2_ASSERT_SAME(a_out_from_busy, $rose(o_out_valid), $past(o_in_stall), "result appeared while idle")

    // a clipped result sits at one of the rails
    `ITD2_ASSERT_SAME(a_sat_rail, o_out_valid && o_out.saturated, o_out.sample_out == 16'sh7FFF || o_out.sample_out == -16'sh8000, "saturated flag without a rail value")

endmodule

bind iir_transposed_direct_form2 itd2_checker u_itd2_checker (.*);
